// File: hw/rtl/kqi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kqi_pkg;

   // Field and arithmetic widths
   localparam int FIELD_W   = 20;
   localparam int COORD_W   = 16;
   localparam int REL_W     = FIELD_W + 1;           // signed field difference
   localparam int DIFF_W    = COORD_W + 1;           // signed corner difference
   localparam int PROD_W    = DIFF_W + REL_W;        // signed product
   localparam int MAG_W     = PROD_W - 1;            // product magnitude
   localparam int SUM_W     = PROD_W + 1;            // position plus quotient
   localparam int DIV_STEPS = MAG_W;                 // one quotient bit per step
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam int DEFAULT_QUEUE_DEPTH = 16;

   // Q2.14 constants
   localparam logic signed [COORD_W-1:0] ONE_Q14  = 16'sd16384;
   localparam logic signed [COORD_W-1:0] HALF_Q14 = 16'sd8192;
   localparam logic signed [COORD_W-1:0] POS_MAX  = 16'sd32767;
   localparam logic signed [COORD_W-1:0] POS_MIN  = -16'sd32768;

   // Opcodes
   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_RENDER = 1'b1;

   // Corner index codes
   localparam logic [1:0] CORNER_TL = 2'd0;
   localparam logic [1:0] CORNER_BL = 2'd1;
   localparam logic [1:0] CORNER_BR = 2'd2;
   localparam logic [1:0] CORNER_TR = 2'd3;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } corner_type;

   typedef struct packed {
      logic [FIELD_W-1:0] field;
      corner_type [3:0]   corner;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CHECK,
      ST_MUL,
      ST_DIV,
      ST_WRITE,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic add;            // add transaction accepted
      logic load_render;    // render transaction accepted
      logic pop;            // make queue head current
      logic start_interp;   // load working corners, set up interpolation
      logic load_plain;     // load working corners, no interpolation
      logic mul;            // form product for one coordinate
      logic div_step;       // one restoring division step
      logic write_coord;    // finish one coordinate
      logic emit_next;      // result transaction taken
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_render;
      logic pop_ok;
      logic interp_ok;
      logic div_last;
      logic coord_last;
      logic corner_last;
   } status_type;

endpackage

`default_nettype wire

// File: hw/rtl/kqi_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface kqi_req_if
   import kqi_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic                      opcode;
   logic [FIELD_W-1:0]        field_number;
   logic signed [COORD_W-1:0] top_left_x;
   logic signed [COORD_W-1:0] top_left_y;
   logic signed [COORD_W-1:0] bottom_left_x;
   logic signed [COORD_W-1:0] bottom_left_y;
   logic signed [COORD_W-1:0] bottom_right_x;
   logic signed [COORD_W-1:0] bottom_right_y;
   logic signed [COORD_W-1:0] top_right_x;
   logic signed [COORD_W-1:0] top_right_y;

   modport source (
      output valid, opcode, field_number,
      output top_left_x, top_left_y, bottom_left_x, bottom_left_y,
      output bottom_right_x, bottom_right_y, top_right_x, top_right_y,
      input  ready
   );

   modport sink (
      input  valid, opcode, field_number,
      input  top_left_x, top_left_y, bottom_left_x, bottom_left_y,
      input  bottom_right_x, bottom_right_y, top_right_x, top_right_y,
      output ready
   );
endinterface

interface kqi_rsp_if
   import kqi_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [1:0]                corner_index;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;
   logic signed [COORD_W-1:0] tex_u;
   logic signed [COORD_W-1:0] tex_v;
   logic                      last_corner;

   modport source (
      output valid, corner_index, pos_x, pos_y, tex_u, tex_v, last_corner,
      input  ready
   );

   modport sink (
      input  valid, corner_index, pos_x, pos_y, tex_u, tex_v, last_corner,
      output ready
   );
endinterface

`default_nettype wire

// File: hw/rtl/kqi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module kqi_ctrl
   import kqi_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type st,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (st.req_render) begin
                  cmd.load_render = 1'b1;
                  state_in        = ST_FETCH;
               end else begin
                  cmd.add = 1'b1;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (st.pop_ok) begin
               cmd.pop  = 1'b1;
               state_in = ST_FETCH;
            end else if (st.interp_ok) begin
               cmd.start_interp = 1'b1;
               state_in         = ST_MUL;
            end else begin
               cmd.load_plain = 1'b1;
               state_in       = ST_EMIT;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (st.div_last) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write_coord = 1'b1;
            state_in        = st.coord_last ? ST_EMIT : ST_MUL;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.emit_next = 1'b1;
               if (st.corner_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: hw/rtl/kqi_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module kqi_datapath
   import kqi_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cmd_type                   cmd,
   output status_type                     st,
   input  wire logic                      req_opcode,
   input  wire logic [FIELD_W-1:0]        req_field_number,
   input  wire logic signed [COORD_W-1:0] req_top_left_x,
   input  wire logic signed [COORD_W-1:0] req_top_left_y,
   input  wire logic signed [COORD_W-1:0] req_bottom_left_x,
   input  wire logic signed [COORD_W-1:0] req_bottom_left_y,
   input  wire logic signed [COORD_W-1:0] req_bottom_right_x,
   input  wire logic signed [COORD_W-1:0] req_bottom_right_y,
   input  wire logic signed [COORD_W-1:0] req_top_right_x,
   input  wire logic signed [COORD_W-1:0] req_top_right_y,
   output logic [1:0]                     rsp_corner_index,
   output logic signed [COORD_W-1:0]      rsp_pos_x,
   output logic signed [COORD_W-1:0]      rsp_pos_y,
   output logic signed [COORD_W-1:0]      rsp_tex_u,
   output logic signed [COORD_W-1:0]      rsp_tex_v,
   output logic                           rsp_last_corner
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   // Keyframe queue memory
   entry_type mem [QUEUE_DEPTH];
   entry_type head_ff;

   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [FIELD_W-1:0] cur_field_ff, cur_field_in;
   corner_type [3:0]   cur_corner_ff, cur_corner_in;
   logic               has_cur_ff, has_cur_in;

   logic [FIELD_W-1:0]  field_ff, field_in;
   corner_type [3:0]    res_ff, res_in;
   logic signed [REL_W-1:0] rel_ff, rel_in;
   logic [FIELD_W-1:0]  delta_ff, delta_in;
   logic [2:0]          coord_ff, coord_in;
   logic [1:0]          corner_ff, corner_in;
   logic                neg_ff, neg_in;
   logic [FIELD_W-1:0]  rem_ff, rem_in;
   logic [MAG_W-1:0]    quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;

   entry_type new_entry;
   logic      push;

   logic signed [COORD_W-1:0] p_val;
   logic signed [COORD_W-1:0] n_val;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [PROD_W-1:0]  prod;
   logic [FIELD_W:0]          shifted;
   logic                      q_bit;
   logic signed [SUM_W-1:0]   q_signed;
   logic signed [SUM_W-1:0]   sum;
   logic signed [COORD_W-1:0] sat_val;

   // Assemble incoming keyframe
   always_comb begin
      new_entry.field            = req_field_number;
      new_entry.corner[0].x      = req_top_left_x;
      new_entry.corner[0].y      = req_top_left_y;
      new_entry.corner[1].x      = req_bottom_left_x;
      new_entry.corner[1].y      = req_bottom_left_y;
      new_entry.corner[2].x      = req_bottom_right_x;
      new_entry.corner[2].y      = req_bottom_right_y;
      new_entry.corner[3].x      = req_top_right_x;
      new_entry.corner[3].y      = req_top_right_y;
      push = cmd.add && (count_ff != CNT_FULL);
   end

   // Write queue, read head
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wptr_ff] <= new_entry;
      end
      head_ff <= mem[rptr_ff];
   end

   // Coordinate arithmetic for the selected working coordinate
   always_comb begin
      p_val = coord_ff[0] ? res_ff[coord_ff[2:1]].y : res_ff[coord_ff[2:1]].x;
      n_val = coord_ff[0] ? head_ff.corner[coord_ff[2:1]].y
                          : head_ff.corner[coord_ff[2:1]].x;
      diff  = DIFF_W'(n_val) - DIFF_W'(p_val);
      prod  = PROD_W'(diff) * PROD_W'(rel_ff);

      shifted = {rem_ff, quo_ff[MAG_W-1]};
      q_bit   = (shifted >= {1'b0, delta_ff});

      q_signed = neg_ff ? -SUM_W'($signed({1'b0, quo_ff}))
                        : SUM_W'($signed({1'b0, quo_ff}));
      sum      = SUM_W'(p_val) + q_signed;
      if (sum > SUM_W'(POS_MAX)) begin
         sat_val = POS_MAX;
      end else if (sum < SUM_W'(POS_MIN)) begin
         sat_val = POS_MIN;
      end else begin
         sat_val = sum[COORD_W-1:0];
      end
   end

   // Next-state logic
   always_comb begin
      wptr_in       = wptr_ff;
      rptr_in       = rptr_ff;
      count_in      = count_ff;
      cur_field_in  = cur_field_ff;
      cur_corner_in = cur_corner_ff;
      has_cur_in    = has_cur_ff;
      field_in      = field_ff;
      res_in        = res_ff;
      rel_in        = rel_ff;
      delta_in      = delta_ff;
      coord_in      = coord_ff;
      corner_in     = corner_ff;
      neg_in        = neg_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;

      // Push keyframe; first one also becomes current
      if (push) begin
         wptr_in  = (wptr_ff == PTR_LAST) ? '0 : wptr_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end
      if (cmd.add && !has_cur_ff) begin
         cur_field_in  = new_entry.field;
         cur_corner_in = new_entry.corner;
         has_cur_in    = 1'b1;
      end

      if (cmd.load_render) begin
         field_in = req_field_number;
      end

      // Retire head keyframe into current
      if (cmd.pop) begin
         cur_field_in  = head_ff.field;
         cur_corner_in = head_ff.corner;
         has_cur_in    = 1'b1;
         rptr_in       = (rptr_ff == PTR_LAST) ? '0 : rptr_ff + 1'b1;
         count_in      = count_ff - 1'b1;
      end

      if (cmd.start_interp || cmd.load_plain) begin
         res_in    = cur_corner_ff;
         corner_in = '0;
      end
      if (cmd.start_interp) begin
         rel_in   = $signed({1'b0, field_ff}) - $signed({1'b0, cur_field_ff});
         delta_in = head_ff.field - cur_field_ff;
         coord_in = '0;
      end

      // Sign-magnitude split of the product
      if (cmd.mul) begin
         neg_in  = prod[PROD_W-1];
         quo_in  = prod[PROD_W-1] ? MAG_W'(-prod) : prod[MAG_W-1:0];
         rem_in  = '0;
         step_in = '0;
      end

      // Restoring division, one quotient bit per step
      if (cmd.div_step) begin
         rem_in  = q_bit ? FIELD_W'(shifted - {1'b0, delta_ff}) : shifted[FIELD_W-1:0];
         quo_in  = {quo_ff[MAG_W-2:0], q_bit};
         step_in = step_ff + 1'b1;
      end

      if (cmd.write_coord) begin
         if (coord_ff[0]) begin
            res_in[coord_ff[2:1]].y = sat_val;
         end else begin
            res_in[coord_ff[2:1]].x = sat_val;
         end
         coord_in = coord_ff + 1'b1;
      end

      if (cmd.emit_next) begin
         corner_in = corner_ff + 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff          <= '0;
         rptr_ff          <= '0;
         count_ff         <= '0;
         cur_field_ff     <= '0;
         cur_corner_ff[0] <= '{x: -ONE_Q14, y: ONE_Q14};
         cur_corner_ff[1] <= '{x: -ONE_Q14, y: -ONE_Q14};
         cur_corner_ff[2] <= '{x: ONE_Q14, y: -ONE_Q14};
         cur_corner_ff[3] <= '{x: ONE_Q14, y: ONE_Q14};
         has_cur_ff       <= 1'b0;
         coord_ff         <= '0;
         corner_ff        <= '0;
         step_ff          <= '0;
      end else begin
         wptr_ff       <= wptr_in;
         rptr_ff       <= rptr_in;
         count_ff      <= count_in;
         cur_field_ff  <= cur_field_in;
         cur_corner_ff <= cur_corner_in;
         has_cur_ff    <= has_cur_in;
         coord_ff      <= coord_in;
         corner_ff     <= corner_in;
         step_ff       <= step_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      field_ff <= field_in;
      res_ff   <= res_in;
      rel_ff   <= rel_in;
      delta_ff <= delta_in;
      neg_ff   <= neg_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
   end

   // Status
   always_comb begin
      st.req_render  = (req_opcode == OP_RENDER);
      st.pop_ok      = (count_ff != '0) && (head_ff.field <= field_ff);
      st.interp_ok   = (count_ff != '0) && (head_ff.field > cur_field_ff);
      st.div_last    = (step_ff == DIV_CNT_W'(DIV_STEPS - 1));
      st.coord_last  = (coord_ff == 3'd7);
      st.corner_last = (corner_ff == CORNER_TR);
   end

   // Result payload: texture coordinate is floor(pos/2) + 0.5
   always_comb begin
      rsp_corner_index = corner_ff;
      rsp_pos_x        = res_ff[corner_ff].x;
      rsp_pos_y        = res_ff[corner_ff].y;
      rsp_tex_u        = (res_ff[corner_ff].x >>> 1) + HALF_Q14;
      rsp_tex_v        = (res_ff[corner_ff].y >>> 1) + HALF_Q14;
      rsp_last_corner  = (corner_ff == CORNER_TR);
   end

endmodule

`default_nettype wire

// File: hw/rtl/keyframe_quad_interpolator_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Keyframe quad interpolator.
// req_chan takes add and render transactions (valid/ready). An add pushes a
// keyframe into the queue (dropped when full); the block stays idle. A render
// pops every queued keyframe at or before the requested field, then returns
// four corner transactions on rsp_chan, top-left first, last_corner on the
// fourth. After the pops, either the four results follow without
// interpolation, or 8 coordinates are interpolated first, each by one
// multiply, 37 steps of the bit-serial divider and one saturating add.
// The divider is shared by all coordinates. req_chan.ready is high only
// while no render is in progress; a stall on rsp_chan holds the current
// corner and the whole block.
// Reset (synchronous) empties the queue and loads the full-screen quad as
// the current keyframe; queue contents need no clearing.
module keyframe_quad_interpolator_top
   import kqi_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  wire logic  clock,
   input  wire logic  reset,
   kqi_req_if.sink    req_chan,
   kqi_rsp_if.source  rsp_chan
);

   cmd_type    cmd;
   status_type st;

   kqi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .st        (st),
      .cmd       (cmd)
   );

   kqi_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .st                 (st),
      .req_opcode         (req_chan.opcode),
      .req_field_number   (req_chan.field_number),
      .req_top_left_x     (req_chan.top_left_x),
      .req_top_left_y     (req_chan.top_left_y),
      .req_bottom_left_x  (req_chan.bottom_left_x),
      .req_bottom_left_y  (req_chan.bottom_left_y),
      .req_bottom_right_x (req_chan.bottom_right_x),
      .req_bottom_right_y (req_chan.bottom_right_y),
      .req_top_right_x    (req_chan.top_right_x),
      .req_top_right_y    (req_chan.top_right_y),
      .rsp_corner_index   (rsp_chan.corner_index),
      .rsp_pos_x          (rsp_chan.pos_x),
      .rsp_pos_y          (rsp_chan.pos_y),
      .rsp_tex_u          (rsp_chan.tex_u),
      .rsp_tex_v          (rsp_chan.tex_v),
      .rsp_last_corner    (rsp_chan.last_corner)
   );

endmodule

`default_nettype wire
